>>> rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// command codes, register indexes and the result record of the bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int CMD_W = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEND     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAIT_ACK = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_UNIT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT_LIMIT = 1'b1;

  localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RESET    = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_error;
  } res_t;

endpackage

>>> rtl/core/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// two-wire bus master bit engine, one input transaction per clock tick
// ----------------------------------------------------------------------------
// Each input transaction is one tick of bus timing: it carries the sampled
// data line level and, while the engine is idle, optionally a command
// (start, stop, send byte, read byte with ack/nack, wait for ack). Each
// accepted tick produces exactly one output transaction with the clock and
// data pin levels, data drive enable, busy, a one-tick done pulse, the last
// received byte and the ack timeout error flag.
// Each tick's result is registered in the output register; one tick is
// accepted every cycle while in_ready is high. The whole tick update is a
// single pass of logic between the state registers and the output register.
// When the receiver stalls, one more result is parked in a skid register, so
// in_ready only drops once both the output and skid registers are full.
// Reset (synchronous) returns the engine to idle with both lines high and
// driven, clears the error flag and received byte, and loads the register
// defaults: one tick per delay unit and a timeout limit of 250.
// The delay unit is clamped to at least one tick and to the width of the
// delay counter.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int DELAY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      command,
  input  logic [7:0]                      tx_byte,
  input  logic                            ack_after_read,
  input  logic                            sda_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            scl_level,
  output logic                            sda_level,
  output logic                            sda_drive,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [7:0]                      rx_byte,
  output logic                            nack_error
);
  import i2cm_pkg::*;

  localparam int UW = (DELAY_BITS > 16) ? DELAY_BITS : 16;
  localparam logic [UW-1:0] UNIT_CAP = UW'({DELAY_BITS{1'b1}});

  // configuration
  logic [15:0] ticks_per_unit;
  logic [7:0]  ack_timeout_limit;

  // engine state
  logic [2:0]            active_command;
  logic [3:0]            phase;
  logic [3:0]            bit_index;
  logic [7:0]            shift_value;
  logic [DELAY_BITS-1:0] delay_count;
  logic [7:0]            timeout_count;
  logic                  ack_choice;
  logic                  scl_reg;
  logic                  sda_reg;
  logic                  drive_reg;
  logic [7:0]            rx_hold;
  logic                  error_flag;

  logic [2:0]            active_command_next;
  logic [3:0]            phase_next;
  logic [3:0]            bit_index_next;
  logic [7:0]            shift_value_next;
  logic [DELAY_BITS-1:0] delay_count_next;
  logic [7:0]            timeout_count_next;
  logic                  ack_choice_next;
  logic                  scl_next;
  logic                  sda_next;
  logic                  drive_next;
  logic [7:0]            rx_hold_next;
  logic                  error_flag_next;
  logic                  done_next;

  // output and skid registers
  res_t out_res;
  res_t skid_res;
  res_t res_next;
  logic skid_valid;

  logic [UW-1:0]         unit_wide;
  logic [DELAY_BITS-1:0] unit_ticks;

  logic in_acc;
  logic out_take;

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_comb begin
    unit_wide = UW'(ticks_per_unit);
    if (unit_wide == '0) begin
      unit_wide = UW'(1);
    end
    if (unit_wide > UNIT_CAP) begin
      unit_wide = UNIT_CAP;
    end
    unit_ticks = unit_wide[DELAY_BITS-1:0];
  end

  // one tick of the engine
  always_comb begin
    logic                  count_en;
    logic                  fin;
    logic                  adv;
    logic [8:0]            tmo_inc;
    logic [DELAY_BITS:0]   dly_inc;
    logic [3:0]            bit_inc;

    active_command_next = active_command;
    phase_next          = phase;
    bit_index_next      = bit_index;
    shift_value_next    = shift_value;
    delay_count_next    = delay_count;
    timeout_count_next  = timeout_count;
    ack_choice_next     = ack_choice;
    scl_next            = scl_reg;
    sda_next            = sda_reg;
    drive_next          = drive_reg;
    rx_hold_next        = rx_hold;
    error_flag_next     = error_flag;
    done_next           = 1'b0;
    count_en            = 1'b1;
    fin                 = 1'b0;
    adv                 = 1'b1;
    tmo_inc             = {1'b0, timeout_count} + 9'd1;
    dly_inc             = '0;
    bit_inc             = bit_index + 4'd1;

    // take a new command only while idle
    if (active_command == CMD_NONE && command >= CMD_START && command <= CMD_WAIT_ACK) begin
      active_command_next = command;
      phase_next          = '0;
      delay_count_next    = '0;
      bit_index_next      = '0;
      case (command)
        CMD_START: begin
          drive_next = 1'b1;
          sda_next   = 1'b1;
          scl_next   = 1'b1;
        end
        CMD_STOP: begin
          drive_next = 1'b1;
          scl_next   = 1'b0;
          sda_next   = 1'b0;
        end
        CMD_SEND: begin
          drive_next       = 1'b1;
          scl_next         = 1'b0;
          sda_next         = tx_byte[7];
          shift_value_next = {tx_byte[6:0], 1'b0};
        end
        CMD_READ: begin
          drive_next       = 1'b0;
          scl_next         = 1'b0;
          shift_value_next = '0;
          ack_choice_next  = ack_after_read;
        end
        default: begin
          drive_next         = 1'b0;
          sda_next           = 1'b1;
          timeout_count_next = '0;
          error_flag_next    = 1'b0;
        end
      endcase
    end

    if (active_command_next != CMD_NONE) begin
      // ack polling phase: sample every tick
      if (active_command_next == CMD_WAIT_ACK && phase_next == 4'd2) begin
        if (!sda_in) begin
          scl_next        = 1'b0;
          error_flag_next = 1'b0;
          fin             = 1'b1;
          count_en        = 1'b0;
        end else begin
          tmo_inc = {1'b0, timeout_count_next} + 9'd1;
          if (tmo_inc > {1'b0, ack_timeout_limit}) begin
            // give up: run a stop sequence from its second half setup
            drive_next       = 1'b1;
            scl_next         = 1'b0;
            sda_next         = 1'b0;
            phase_next       = 4'd3;
            delay_count_next = '0;
          end else begin
            timeout_count_next = tmo_inc[7:0];
            count_en           = 1'b0;
          end
        end
      end

      if (count_en) begin
        dly_inc = {1'b0, delay_count_next} + {{DELAY_BITS{1'b0}}, 1'b1};
        if (dly_inc >= {1'b0, unit_ticks}) begin
          delay_count_next = '0;
          bit_inc          = bit_index_next + 4'd1;
          // end of one delay unit
          case (active_command_next)
            CMD_START: begin
              if (phase_next == 4'd3) sda_next = 1'b0;
              if (phase_next == 4'd7) begin
                scl_next = 1'b0;
                fin      = 1'b1;
              end
            end
            CMD_STOP: begin
              if (phase_next == 4'd3) begin
                scl_next = 1'b1;
                sda_next = 1'b1;
              end
              if (phase_next == 4'd7) fin = 1'b1;
            end
            CMD_SEND: begin
              if (phase_next == 4'd1) scl_next = 1'b1;
              if (phase_next == 4'd3) scl_next = 1'b0;
              if (phase_next == 4'd5) begin
                bit_index_next = bit_inc;
                if (bit_inc >= BITS_PER_BYTE) begin
                  fin = 1'b1;
                end else begin
                  sda_next         = shift_value_next[7];
                  shift_value_next = {shift_value_next[6:0], 1'b0};
                  phase_next       = '0;
                  adv              = 1'b0;
                end
              end
            end
            CMD_READ: begin
              if (phase_next == 4'd1) begin
                scl_next         = 1'b1;
                shift_value_next = {shift_value_next[6:0], sda_in};
              end
              if (phase_next == 4'd2) begin
                bit_index_next = bit_inc;
                scl_next       = 1'b0;
                if (bit_inc < BITS_PER_BYTE) begin
                  phase_next = '0;
                  adv        = 1'b0;
                end else begin
                  rx_hold_next = shift_value_next;
                  drive_next   = 1'b1;
                  sda_next     = !ack_choice_next;
                end
              end
              if (phase_next == 4'd4) scl_next = 1'b1;
              if (phase_next == 4'd6) begin
                scl_next = 1'b0;
                fin      = 1'b1;
              end
            end
            CMD_WAIT_ACK: begin
              if (phase_next == 4'd0) scl_next = 1'b1;
              if (phase_next == 4'd6) begin
                scl_next = 1'b1;
                sda_next = 1'b1;
              end
              if (phase_next == 4'd10) begin
                error_flag_next = 1'b1;
                fin             = 1'b1;
              end
            end
            default: begin
              adv = 1'b1;
            end
          endcase
          if (!fin && adv) begin
            phase_next = phase_next + 4'd1;
          end
        end else begin
          delay_count_next = dly_inc[DELAY_BITS-1:0];
        end
      end

      if (fin) begin
        active_command_next = CMD_NONE;
        phase_next          = '0;
        bit_index_next      = '0;
        delay_count_next    = '0;
        done_next           = 1'b1;
      end
    end

    res_next.scl_level  = scl_next;
    res_next.sda_level  = sda_next;
    res_next.sda_drive  = drive_next;
    res_next.busy_res   = (active_command_next != CMD_NONE);
    res_next.done_res   = done_next;
    res_next.rx_byte    = rx_hold_next;
    res_next.nack_error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit    <= TICKS_PER_UNIT_RESET;
      ack_timeout_limit <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT:    ticks_per_unit    <= cfg_data;
        CFG_ACK_TIMEOUT_LIMIT: ack_timeout_limit <= cfg_data[7:0];
        default: begin
          ticks_per_unit <= ticks_per_unit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= CMD_NONE;
      phase          <= '0;
      bit_index      <= '0;
      shift_value    <= '0;
      delay_count    <= '0;
      timeout_count  <= '0;
      ack_choice     <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      drive_reg      <= 1'b1;
      rx_hold        <= '0;
      error_flag     <= 1'b0;
    end else if (in_acc) begin
      active_command <= active_command_next;
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      shift_value    <= shift_value_next;
      delay_count    <= delay_count_next;
      timeout_count  <= timeout_count_next;
      ack_choice     <= ack_choice_next;
      scl_reg        <= scl_next;
      sda_reg        <= sda_next;
      drive_reg      <= drive_next;
      rx_hold        <= rx_hold_next;
      error_flag     <= error_flag_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        out_res <= res_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign scl_level  = out_res.scl_level;
  assign sda_level  = out_res.sda_level;
  assign sda_drive  = out_res.sda_drive;
  assign busy_res   = out_res.busy_res;
  assign done_res   = out_res.done_res;
  assign rx_byte    = out_res.rx_byte;
  assign nack_error = out_res.nack_error;

endmodule
